// ===== rtl/core/tles_pkg.sv =====
`default_nettype none
package tles_pkg;

  localparam int CW   = 33;  // coordinate difference
  localparam int PW   = 66;  // product / doubled area
  localparam int NW   = 83;  // scaled numerator plus rounding term
  localparam int RW   = 68;  // divider partial remainder
  localparam int QW   = 32;  // quotient bits
  localparam int OutFrac = 16;
  localparam int DefMaxNodes = 65536;

  typedef enum logic {
    REG_NODE_COUNT = 1'b0,
    REG_AREA_THR   = 1'b1
  } reg_e;

  typedef struct packed {
    logic [2:0][15:0]   node;
    logic [2:0][CW-1:0] b;
    logic [2:0][CW-1:0] c;
    logic               last;
  } geo_t;

  typedef struct packed {
    geo_t          geo;
    logic [PW-1:0] area;
  } tri_t;

  typedef struct packed {
    logic [15:0] row;
    logic [15:0] col;
    logic [31:0] flat;
    logic        last_run;
    logic        end_mesh;
  } tag_t;

  typedef struct packed {
    logic [NW-1:0] num;
    logic [PW-1:0] area;
    logic          neg;
    tag_t          tag;
  } div_in_t;

  typedef struct packed {
    tag_t        tag;
    logic [31:0] value;
    logic        sat;
  } res_t;

endpackage
`default_nettype wire

// ===== rtl/core/tles_front.sv =====
`default_nettype none
module tles_front import tles_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] node_a_i,
  input  wire logic [15:0] node_b_i,
  input  wire logic [15:0] node_c_i,
  input  wire logic [31:0] x_a_i,
  input  wire logic [31:0] y_a_i,
  input  wire logic [31:0] x_b_i,
  input  wire logic [31:0] y_b_i,
  input  wire logic [31:0] x_c_i,
  input  wire logic [31:0] y_c_i,
  input  wire logic        last_element_i,
  input  wire logic [31:0] area_thr_i,
  input  wire logic        seq_slot_i,
  output logic             tri_valid_o,
  output tri_t             tri_o
);

  logic a_v_q, b_v_q, c_v_q, d_v_q;
  geo_t a_geo_q, b_geo_q, c_geo_q, d_geo_q, a_geo_d;
  logic signed [PW-1:0] b_p1_q, b_p2_q, b_p1_d, b_p2_d, c_diff_q;
  logic [PW-1:0] d_area_q;
  logic en_a, en_b, en_c, en_d, skip;

  assign skip = d_area_q <= {{(PW-32){1'b0}}, area_thr_i};
  assign en_d = adv_i & (~d_v_q | skip | seq_slot_i);
  assign en_c = (adv_i & ~c_v_q) | en_d;
  assign en_b = (adv_i & ~b_v_q) | en_c;
  assign en_a = (adv_i & ~a_v_q) | en_b;
  assign in_stall_o = ~en_a;

  always_comb begin
    a_geo_d.node[0] = node_a_i;
    a_geo_d.node[1] = node_b_i;
    a_geo_d.node[2] = node_c_i;
    a_geo_d.b[0] = {y_b_i[31], y_b_i} - {y_c_i[31], y_c_i};
    a_geo_d.b[1] = {y_c_i[31], y_c_i} - {y_a_i[31], y_a_i};
    a_geo_d.b[2] = {y_a_i[31], y_a_i} - {y_b_i[31], y_b_i};
    a_geo_d.c[0] = {x_c_i[31], x_c_i} - {x_b_i[31], x_b_i};
    a_geo_d.c[1] = {x_a_i[31], x_a_i} - {x_c_i[31], x_c_i};
    a_geo_d.c[2] = {x_b_i[31], x_b_i} - {x_a_i[31], x_a_i};
    a_geo_d.last = last_element_i;
  end

  // area2 = |c2*b1 - c1*b2|
  always_comb begin
    logic signed [CW-1:0] c2, b1, c1, b2;
    c2 = a_geo_q.c[2];
    b1 = a_geo_q.b[1];
    c1 = a_geo_q.c[1];
    b2 = a_geo_q.b[2];
    b_p1_d = PW'(c2) * PW'(b1);
    b_p2_d = PW'(c1) * PW'(b2);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_v_q <= 1'b0;
      b_v_q <= 1'b0;
      c_v_q <= 1'b0;
      d_v_q <= 1'b0;
    end else begin
      if (en_a) a_v_q <= in_valid_i;
      if (en_b) b_v_q <= a_v_q;
      if (en_c) c_v_q <= b_v_q;
      if (en_d) d_v_q <= c_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_a) a_geo_q <= a_geo_d;
    if (en_b) begin
      b_geo_q <= a_geo_q;
      b_p1_q  <= b_p1_d;
      b_p2_q  <= b_p2_d;
    end
    if (en_c) begin
      c_geo_q  <= b_geo_q;
      c_diff_q <= b_p1_q - b_p2_q;
    end
    if (en_d) begin
      d_geo_q  <= c_geo_q;
      d_area_q <= c_diff_q[PW-1] ? PW'(-c_diff_q) : PW'(c_diff_q);
    end
  end

  assign tri_valid_o = d_v_q & ~skip;
  assign tri_o.geo   = d_geo_q;
  assign tri_o.area  = d_area_q;

endmodule
`default_nettype wire

// ===== rtl/core/tles_entry.sv =====
`default_nettype none
module tles_entry import tles_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        adv_i,
  input  wire logic        tri_valid_i,
  input  wire tri_t        tri_i,
  input  wire logic [16:0] node_count_i,
  output logic             seq_slot_o,
  output logic             ent_valid_o,
  output div_in_t          ent_o
);

  logic       seq_v_q;
  tri_t       seq_q;
  logic [1:0] i_q, j_q;
  logic       seq_last;

  logic                 e1_v_q, e2_v_q, e3_v_q, e4_v_q;
  logic signed [PW-1:0] e1_pb_q, e1_pc_q, pb_d, pc_d, e2_num_q;
  logic [15:0]          e1_row_q, e1_col_q;
  logic                 e1_lr_q, e1_em_q;
  logic [PW-1:0]        e1_area_q, e2_area_q, e3_area_q, e3_mag_q;
  tag_t                 e2_tag_q, e3_tag_q, e4_tag_q;
  logic                 e3_neg_q, e4_neg_q;
  logic [NW-1:0]        e4_num_q;
  logic [PW-1:0]        e4_area_q;
  logic [31:0]          prod;

  assign seq_last   = (i_q == 2'd2) && (j_q == 2'd2);
  assign seq_slot_o = ~seq_v_q | seq_last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_v_q <= 1'b0;
      i_q     <= 2'd0;
      j_q     <= 2'd0;
    end else if (adv_i) begin
      if (seq_slot_o) begin
        seq_v_q <= tri_valid_i;
        i_q     <= 2'd0;
        j_q     <= 2'd0;
      end else if (j_q == 2'd2) begin
        i_q <= i_q + 2'd1;
        j_q <= 2'd0;
      end else begin
        j_q <= j_q + 2'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i && seq_slot_o) seq_q <= tri_i;
  end

  always_comb begin
    logic signed [CW-1:0] bi, bj, ci, cj;
    bi = seq_q.geo.b[i_q];
    bj = seq_q.geo.b[j_q];
    ci = seq_q.geo.c[i_q];
    cj = seq_q.geo.c[j_q];
    pb_d = PW'(bi) * PW'(bj);
    pc_d = PW'(ci) * PW'(cj);
  end

  assign prod = {16'd0, e1_row_q} * {15'd0, node_count_i};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      e1_v_q <= 1'b0;
      e2_v_q <= 1'b0;
      e3_v_q <= 1'b0;
      e4_v_q <= 1'b0;
    end else if (adv_i) begin
      e1_v_q <= seq_v_q;
      e2_v_q <= e1_v_q;
      e3_v_q <= e2_v_q;
      e4_v_q <= e3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      e1_pb_q   <= pb_d;
      e1_pc_q   <= pc_d;
      e1_row_q  <= seq_q.geo.node[i_q];
      e1_col_q  <= seq_q.geo.node[j_q];
      e1_lr_q   <= seq_last;
      e1_em_q   <= seq_last & seq_q.geo.last;
      e1_area_q <= seq_q.area;

      e2_num_q          <= e1_pb_q + e1_pc_q;
      e2_area_q         <= e1_area_q;
      e2_tag_q.row      <= e1_row_q;
      e2_tag_q.col      <= e1_col_q;
      e2_tag_q.flat     <= prod + {16'd0, e1_col_q};
      e2_tag_q.last_run <= e1_lr_q;
      e2_tag_q.end_mesh <= e1_em_q;

      e3_neg_q  <= e2_num_q[PW-1];
      e3_mag_q  <= e2_num_q[PW-1] ? PW'(-e2_num_q) : PW'(e2_num_q);
      e3_area_q <= e2_area_q;
      e3_tag_q  <= e2_tag_q;

      // scale to the output fraction and add half the divisor for rounding
      e4_num_q  <= {1'b0, e3_mag_q, {OutFrac{1'b0}}} + {{(NW-PW){1'b0}}, e3_area_q};
      e4_area_q <= e3_area_q;
      e4_neg_q  <= e3_neg_q;
      e4_tag_q  <= e3_tag_q;
    end
  end

  assign ent_valid_o = e4_v_q;
  assign ent_o.num   = e4_num_q;
  assign ent_o.area  = e4_area_q;
  assign ent_o.neg   = e4_neg_q;
  assign ent_o.tag   = e4_tag_q;

endmodule
`default_nettype wire

// ===== rtl/core/tles_div.sv =====
`default_nettype none
module tles_div import tles_pkg::*; (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire logic    adv_i,
  input  wire logic    ent_valid_i,
  input  wire div_in_t ent_i,
  output logic         res_valid_o,
  output res_t         res_o
);

  localparam int HiW = NW - QW;

  // index 0 is the overflow check stage, 1..QW are quotient bit stages
  logic          st_v   [QW+1];
  logic [RW-1:0] st_rem [QW+1];
  logic [QW-1:0] st_q   [QW+1];
  logic [QW-1:0] st_low [QW+1];
  logic [RW-1:0] st_d   [QW+1];
  logic          st_ovf [QW+1];
  logic          st_neg [QW+1];
  tag_t          st_tag [QW+1];

  logic [RW-1:0] hi_ext, dvs;
  logic          res_v_q;
  res_t          res_q, res_d;

  assign hi_ext = {{(RW-HiW){1'b0}}, ent_i.num[NW-1:QW]};
  assign dvs    = {{(RW-PW-1){1'b0}}, ent_i.area, 1'b0};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) st_v[0] <= 1'b0;
    else if (adv_i) st_v[0] <= ent_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      st_rem[0] <= hi_ext;
      st_ovf[0] <= hi_ext >= dvs;
      st_q[0]   <= '0;
      st_low[0] <= ent_i.num[QW-1:0];
      st_d[0]   <= dvs;
      st_neg[0] <= ent_i.neg;
      st_tag[0] <= ent_i.tag;
    end
  end

  for (genvar s = 1; s <= QW; s++) begin : g_stage
    logic [RW-1:0] trial;
    logic          ge;
    assign trial = {st_rem[s-1][RW-2:0], st_low[s-1][QW-1]};
    assign ge    = trial >= st_d[s-1];

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) st_v[s] <= 1'b0;
      else if (adv_i) st_v[s] <= st_v[s-1];
    end

    always_ff @(posedge clk_i) begin
      if (adv_i) begin
        st_rem[s] <= ge ? trial - st_d[s-1] : trial;
        st_q[s]   <= {st_q[s-1][QW-2:0], ge};
        st_low[s] <= {st_low[s-1][QW-2:0], 1'b0};
        st_d[s]   <= st_d[s-1];
        st_ovf[s] <= st_ovf[s-1];
        st_neg[s] <= st_neg[s-1];
        st_tag[s] <= st_tag[s-1];
      end
    end
  end

  always_comb begin
    logic [QW-1:0] q;
    q = st_q[QW];
    res_d.tag = st_tag[QW];
    if (st_neg[QW]) begin
      res_d.sat   = st_ovf[QW] | (q > 32'h8000_0000);
      res_d.value = res_d.sat ? 32'h8000_0000 : (32'd0 - q);
    end else begin
      res_d.sat   = st_ovf[QW] | q[QW-1];
      res_d.value = res_d.sat ? 32'h7FFF_FFFF : q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) res_v_q <= 1'b0;
    else if (adv_i) res_v_q <= st_v[QW];
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) res_q <= res_d;
  end

  assign res_valid_o = res_v_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/triangle_laplacian_element_stiffness_top.sv =====
// Linear triangle Laplacian element stiffness generator. Each input transaction carries one
// triangle (three node numbers, signed Q16.16 vertex coordinates, end-of-mesh flag); the
// block emits the nine entries (bi*bj+ci*cj)/(2*area2) of the element matrix in row-major
// order, rounded to nearest (ties away from zero) and saturated to Q16.16, each tagged with
// row node, column node and flat index row*node_count+col. Triangles whose doubled area is
// at or below area_threshold produce nothing. The entry sequencer issues one matrix entry per
// cycle while no finished entry is held back, and takes a new triangle as it issues the
// last entry of the previous one; a skipped triangle is dropped at the area stage. Each entry
// passes 43 register stages (4 area stages, sequencer, 4 numerator stages, 33
// divider stages, output register). A stall on a valid output freezes the whole pipeline.
// Registers (APB, write/read): 0x0 node_count (17 bits, clamped to MAX_NODES), 0x4
// area_threshold (32 bits, unsigned Q0.32).
// Write registers only while the block is idle.
`default_nettype none
module triangle_laplacian_element_stiffness_top import tles_pkg::*; #(
  parameter int MAX_NODES = DefMaxNodes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [15:0] node_a_i,
  input  wire logic [15:0] node_b_i,
  input  wire logic [15:0] node_c_i,
  input  wire logic [31:0] x_a_i,
  input  wire logic [31:0] y_a_i,
  input  wire logic [31:0] x_b_i,
  input  wire logic [31:0] y_b_i,
  input  wire logic [31:0] x_c_i,
  input  wire logic [31:0] y_c_i,
  input  wire logic        last_element_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [15:0]      row_node_o,
  output logic [15:0]      col_node_o,
  output logic [31:0]      flat_index_o,
  output logic [31:0]      entry_value_o,
  output logic             saturated_o,
  output logic             last_of_run_o,
  output logic             end_of_mesh_o
);

  localparam logic [16:0] NcReset = (MAX_NODES < 65536) ? 17'(MAX_NODES) : 17'd65536;

  logic [16:0] node_count_q;
  logic [31:0] area_thr_q;
  reg_e        reg_sel;
  logic        wr_en;

  // global advance: everything moves unless a finished entry is held back
  logic    adv;
  logic    tri_valid, seq_slot, ent_valid, res_valid;
  tri_t    tri_w;
  div_in_t ent;
  res_t    res;

  // ---- configuration port ----
  assign pready  = 1'b1;
  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q <= NcReset;
      area_thr_q   <= '0;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_NODE_COUNT: begin
          node_count_q <= ({15'd0, pwdata[16:0]} > 32'(MAX_NODES)) ?
                          17'(MAX_NODES) : pwdata[16:0];
        end
        REG_AREA_THR: area_thr_q <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_NODE_COUNT: prdata = {15'd0, node_count_q};
      REG_AREA_THR:   prdata = area_thr_q;
      default:        prdata = '0;
    endcase
  end

  // ---- datapath ----
  assign adv = ~(res_valid & out_stall_i);

  tles_front u_front (
    .clk_i, .rst_ni,
    .adv_i          (adv),
    .in_valid_i,
    .in_stall_o,
    .node_a_i, .node_b_i, .node_c_i,
    .x_a_i, .y_a_i, .x_b_i, .y_b_i, .x_c_i, .y_c_i,
    .last_element_i,
    .area_thr_i     (area_thr_q),
    .seq_slot_i     (seq_slot),
    .tri_valid_o    (tri_valid),
    .tri_o          (tri_w)
  );

  tles_entry u_entry (
    .clk_i, .rst_ni,
    .adv_i        (adv),
    .tri_valid_i  (tri_valid),
    .tri_i        (tri_w),
    .node_count_i (node_count_q),
    .seq_slot_o   (seq_slot),
    .ent_valid_o  (ent_valid),
    .ent_o        (ent)
  );

  tles_div u_div (
    .clk_i, .rst_ni,
    .adv_i       (adv),
    .ent_valid_i (ent_valid),
    .ent_i       (ent),
    .res_valid_o (res_valid),
    .res_o       (res)
  );

  assign out_valid_o   = res_valid;
  assign row_node_o    = res.tag.row;
  assign col_node_o    = res.tag.col;
  assign flat_index_o  = res.tag.flat;
  assign entry_value_o = res.value;
  assign saturated_o   = res.sat;
  assign last_of_run_o = res.tag.last_run;
  assign end_of_mesh_o = res.tag.end_mesh;

  // ---- checks ----
  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_mesh_o |-> last_of_run_o)
    else $error("end_of_mesh without last_of_run");

  a_sat_value: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && saturated_o |->
      (entry_value_o == 32'h7FFF_FFFF) || (entry_value_o == 32'h8000_0000))
    else $error("saturated entry not at a rail");

  a_stall_back: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |-> in_stall_o)
    else $error("input accepted while pipeline frozen");

endmodule
`default_nettype wire
